/* hw/rtl/tdee_pkg.sv */
// Shared types and constants of the timed converter event encoder.
`default_nettype none

package tdee_pkg;

   localparam int TIME_BITS_DEF = 48;

   // Configuration register indexes.
   localparam logic [1:0] CSR_MIN_SPACING   = 2'd0;
   localparam logic [1:0] CSR_MIN_START     = 2'd1;
   localparam logic [1:0] CSR_HOLDOFF       = 2'd2;
   localparam logic [1:0] CSR_TRIGGER_DELAY = 2'd3;

   // Configuration reset values.
   localparam logic [19:0] MIN_SPACING_RST   = 20'd1050;
   localparam logic [23:0] MIN_START_RST     = 24'd10000;
   localparam logic [19:0] HOLDOFF_RST       = 20'd5150;
   localparam logic [23:0] TRIGGER_DELAY_RST = 24'd0;

   // Verdict codes.
   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_EARLY   = 3'd1;
   localparam logic [2:0] ST_CLOSE   = 3'd2;
   localparam logic [2:0] ST_SIMUL   = 3'd3;
   localparam logic [2:0] ST_RANGE   = 3'd4;
   localparam logic [2:0] ST_ABORTED = 3'd5;

   // Voltage limit, +-10 V at 1/1024 V per step.
   localparam logic signed [15:0] VOLT_LIMIT = 16'sd10240;

   // Code scaling: n * 16383 / 20480, with 16383 = 2^14 - 1 and 20480 = 2^12 * 5.
   localparam int CODE_BITS      = 14;
   localparam int DIV_SHIFT      = 12;
   localparam logic [15:0] RECIP_5 = 16'd52429;  // ceil(2^18 / 5)
   localparam int RECIP_SHIFT    = 18;

   // Command word fixed fields.
   localparam logic [1:0] REG_FIELD = 2'b11;
   localparam logic       UPDATE_BIT = 1'b1;
   localparam logic       RESET_BIT  = 1'b0;

   typedef struct packed {
      logic [19:0] min_spacing;
      logic [23:0] min_start;
      logic [19:0] holdoff;
      logic [23:0] trigger_delay;
   } cfg_type;

endpackage

`default_nettype wire

/* hw/rtl/tdee_check.sv */
// Sequence checks and the per-sequence state of the event encoder.
`default_nettype none

module tdee_check #(
   parameter int TIME_BITS = tdee_pkg::TIME_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  fire,
   input  wire logic [TIME_BITS-1:0]  event_time,
   input  wire logic [3:0]            events_at_time,
   input  wire logic signed [15:0]    voltage,
   input  wire logic                  seq_start,
   input  wire tdee_pkg::cfg_type     cfg,
   output logic [2:0]                 status
);

   localparam int W = TIME_BITS + 2;

   logic [TIME_BITS-1:0] last_ff, last_in;
   logic                 aborted_ff, aborted_in;

   logic signed [W-1:0] t_ext;
   logic signed [W-1:0] start_lim;
   logic [W-1:0]        close_lim;
   logic                early;
   logic                close;
   logic                multi;
   logic                volt_bad;

   always_comb begin
      t_ext     = $signed({2'b00, event_time});
      start_lim = $signed({{(W - 24){1'b0}}, cfg.min_start})
                + $signed({{(W - 24){cfg.trigger_delay[23]}}, cfg.trigger_delay});
      close_lim = {2'b00, last_ff} + {{(W - 20){1'b0}}, cfg.min_spacing};
      early     = t_ext < start_lim;
      close     = {2'b00, event_time} < close_lim;
      multi     = events_at_time > 4'd1;
      volt_bad  = (voltage > tdee_pkg::VOLT_LIMIT) || (voltage < -tdee_pkg::VOLT_LIMIT);
   end

   always_comb begin
      status = tdee_pkg::ST_OK;
      if (seq_start) begin
         if (early) status = tdee_pkg::ST_EARLY;
      end else if (aborted_ff) begin
         status = tdee_pkg::ST_ABORTED;
      end else if (close) begin
         status = tdee_pkg::ST_CLOSE;
      end
      if (status == tdee_pkg::ST_OK && multi) status = tdee_pkg::ST_SIMUL;
      if (status == tdee_pkg::ST_OK && volt_bad) status = tdee_pkg::ST_RANGE;
   end

   // A good item moves the reference time; any error keeps the sequence aborted.
   always_comb begin
      last_in    = last_ff;
      aborted_in = aborted_ff;
      if (fire) begin
         aborted_in = (status != tdee_pkg::ST_OK);
         if (status == tdee_pkg::ST_OK) last_in = event_time;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff    <= '0;
         aborted_ff <= 1'b0;
      end else begin
         last_ff    <= last_in;
         aborted_ff <= aborted_in;
      end
   end

   a_ok_moves_last: assert property (@(posedge clock) disable iff (reset)
      fire && status == tdee_pkg::ST_OK |=> last_ff == $past(event_time))
      else $error("last event time not taken from good item");

   a_err_keeps_last: assert property (@(posedge clock) disable iff (reset)
      fire && status != tdee_pkg::ST_OK |=> $stable(last_ff) && aborted_ff)
      else $error("failed item changed last time or did not abort");

   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(last_ff) && $stable(aborted_ff))
      else $error("sequence state moved without an item");

   a_abort_only_set: assert property (@(posedge clock) disable iff (reset)
      fire && status == tdee_pkg::ST_ABORTED |-> aborted_ff && !seq_start)
      else $error("aborted verdict outside an aborted sequence");

endmodule

`default_nettype wire

/* hw/rtl/tdee_encode.sv */
// Trigger time and command word of an event.
`default_nettype none

module tdee_encode #(
   parameter int TIME_BITS = tdee_pkg::TIME_BITS_DEF
) (
   input  wire logic [TIME_BITS-1:0]    event_time,
   input  wire logic [5:0]              dac_channel,
   input  wire logic signed [15:0]      voltage,
   input  wire tdee_pkg::cfg_type       cfg,
   output logic signed [TIME_BITS:0]    trigger_time,
   output logic [23:0]                  command_word
);

   localparam int W = TIME_BITS + 2;
   localparam int CB = tdee_pkg::CODE_BITS;

   logic signed [W-1:0] trig_raw;
   logic signed [W-1:0] trig_hi;
   logic signed [W-1:0] trig_lo;
   logic signed [16:0]  offset;
   logic [14:0]         mag;
   logic [28:0]         scaled;
   logic [16:0]         quarter;
   logic [32:0]         prod;
   logic [CB-1:0]       code;

   always_comb begin
      trig_hi  = $signed({2'b00, {TIME_BITS{1'b1}}});
      trig_lo  = $signed({2'b11, {TIME_BITS{1'b0}}});
      trig_raw = $signed({2'b00, event_time})
               - $signed({{(W - 20){1'b0}}, cfg.holdoff})
               - $signed({{(W - 24){cfg.trigger_delay[23]}}, cfg.trigger_delay});
      if (trig_raw > trig_hi) begin
         trigger_time = trig_hi[TIME_BITS:0];
      end else if (trig_raw < trig_lo) begin
         trigger_time = trig_lo[TIME_BITS:0];
      end else begin
         trigger_time = trig_raw[TIME_BITS:0];
      end
   end

   // Inverted code: (10240 - v) * 16383 / 20480, only used for in-range voltages.
   always_comb begin
      offset  = 17'(tdee_pkg::VOLT_LIMIT) - 17'(voltage);
      mag     = offset[14:0];
      scaled  = ({14'd0, mag} << CB) - {14'd0, mag};
      quarter = scaled[28:tdee_pkg::DIV_SHIFT];
      // divide by 5 through the reciprocal; exact for this range
      prod    = {16'd0, quarter} * {17'd0, tdee_pkg::RECIP_5};
      code    = prod[tdee_pkg::RECIP_SHIFT +: CB];
   end

   assign command_word = {tdee_pkg::RESET_BIT, tdee_pkg::REG_FIELD, dac_channel[5:2],
                          dac_channel[0], dac_channel[1], tdee_pkg::UPDATE_BIT, code};

endmodule

`default_nettype wire

/* hw/rtl/timed_dac_event_encoder.sv */
// Pipeline: an accepted item goes through the input register, then the result register.
// Throughput: one item per cycle unless rsp_ready stalls; a stall admits one more item.
// Sequence state updates as an item moves to the result register, ready for the next cycle.
// Reset (synchronous): empties both registers, clears the last event time and the abort flag,
// and returns the configuration registers to their reset values.
`default_nettype none

module timed_dac_event_encoder #(
   parameter int TIME_BITS = tdee_pkg::TIME_BITS_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_we,
   input  wire logic [1:0]              csr_index,
   input  wire logic [23:0]             csr_wdata,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic [TIME_BITS-1:0]    req_event_time_ns,
   input  wire logic [5:0]              req_dac_channel,
   input  wire logic signed [15:0]      req_voltage_q10,
   input  wire logic [3:0]              req_events_at_time,
   input  wire logic                    req_sequence_start,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic [2:0]                   rsp_status,
   output logic signed [TIME_BITS:0]    rsp_trigger_time_ns,
   output logic [23:0]                  rsp_command_word
);

   tdee_pkg::cfg_type cfg_ff, cfg_in;

   logic                 in_valid_ff, in_valid_in;
   logic [TIME_BITS-1:0] in_time_ff, in_time_in;
   logic [5:0]           in_chan_ff, in_chan_in;
   logic signed [15:0]   in_volt_ff, in_volt_in;
   logic [3:0]           in_count_ff, in_count_in;
   logic                 in_start_ff, in_start_in;

   logic                     out_valid_ff, out_valid_in;
   logic [2:0]               out_status_ff, out_status_in;
   logic signed [TIME_BITS:0] out_trig_ff, out_trig_in;
   logic [23:0]              out_word_ff, out_word_in;

   logic                      take;
   logic                      advance;
   logic [2:0]                status;
   logic signed [TIME_BITS:0] enc_trig;
   logic [23:0]               enc_word;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            tdee_pkg::CSR_MIN_SPACING:   cfg_in.min_spacing   = csr_wdata[19:0];
            tdee_pkg::CSR_MIN_START:     cfg_in.min_start     = csr_wdata;
            tdee_pkg::CSR_HOLDOFF:       cfg_in.holdoff       = csr_wdata[19:0];
            tdee_pkg::CSR_TRIGGER_DELAY: cfg_in.trigger_delay = csr_wdata;
            default: ;
         endcase
      end
   end

   // Advance the held item when the result register is empty or being drained.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign take      = req_valid && req_ready;

   always_comb begin
      in_valid_in = take || (in_valid_ff && !advance);
      in_time_in  = in_time_ff;
      in_chan_in  = in_chan_ff;
      in_volt_in  = in_volt_ff;
      in_count_in = in_count_ff;
      in_start_in = in_start_ff;
      if (take) begin
         in_time_in  = req_event_time_ns;
         in_chan_in  = req_dac_channel;
         in_volt_in  = req_voltage_q10;
         in_count_in = req_events_at_time;
         in_start_in = req_sequence_start;
      end
   end

   tdee_check #(.TIME_BITS(TIME_BITS)) u_check (
      .clock          (clock),
      .reset          (reset),
      .fire           (advance),
      .event_time     (in_time_ff),
      .events_at_time (in_count_ff),
      .voltage        (in_volt_ff),
      .seq_start      (in_start_ff),
      .cfg            (cfg_ff),
      .status         (status)
   );

   tdee_encode #(.TIME_BITS(TIME_BITS)) u_encode (
      .event_time   (in_time_ff),
      .dac_channel  (in_chan_ff),
      .voltage      (in_volt_ff),
      .cfg          (cfg_ff),
      .trigger_time (enc_trig),
      .command_word (enc_word)
   );

   // Drop trigger time and command word of a failed item.
   always_comb begin
      out_valid_in  = advance || (out_valid_ff && !rsp_ready);
      out_status_in = out_status_ff;
      out_trig_in   = out_trig_ff;
      out_word_in   = out_word_ff;
      if (advance) begin
         out_status_in = status;
         out_trig_in   = (status == tdee_pkg::ST_OK) ? enc_trig : '0;
         out_word_in   = (status == tdee_pkg::ST_OK) ? enc_word : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_spacing   <= tdee_pkg::MIN_SPACING_RST;
         cfg_ff.min_start     <= tdee_pkg::MIN_START_RST;
         cfg_ff.holdoff       <= tdee_pkg::HOLDOFF_RST;
         cfg_ff.trigger_delay <= tdee_pkg::TRIGGER_DELAY_RST;
         in_valid_ff          <= 1'b0;
         out_valid_ff         <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_time_ff    <= in_time_in;
      in_chan_ff    <= in_chan_in;
      in_volt_ff    <= in_volt_in;
      in_count_ff   <= in_count_in;
      in_start_ff   <= in_start_in;
      out_status_ff <= out_status_in;
      out_trig_ff   <= out_trig_in;
      out_word_ff   <= out_word_in;
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_status          = out_status_ff;
   assign rsp_trigger_time_ns = out_trig_ff;
   assign rsp_command_word    = out_word_ff;

endmodule

`default_nettype wire

/* test/tb.sv */
`timescale 1ns / 100ps
// Testbench of the timed converter event encoder: directed and random events.

module tb;

   localparam int TB_TIME_BITS = tdee_pkg::TIME_BITS_DEF;
   localparam longint TRIG_MAX = (longint'(1) <<< TB_TIME_BITS) - 1;
   localparam longint TRIG_MIN = -(longint'(1) <<< TB_TIME_BITS);
   localparam longint CODE_FULL = (longint'(1) <<< tdee_pkg::CODE_BITS) - 1;
   localparam int HOLD_CYCLES = 300;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct packed {
      logic [TB_TIME_BITS-1:0] time_ns;
      logic [5:0]              channel;
      logic [15:0]             volt;
      logic [3:0]              count;
      logic                    start;
   } dac_event_type;

   typedef struct packed {
      logic [2:0]            status;
      logic [TB_TIME_BITS:0] trig;
      logic [23:0]           word;
   } verdict_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [1:0] csr_index = tdee_pkg::CSR_MIN_SPACING;
   logic [23:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [TB_TIME_BITS-1:0] req_event_time_ns = '0;
   logic [5:0] req_dac_channel = '0;
   logic signed [15:0] req_voltage_q10 = '0;
   logic [3:0] req_events_at_time = 4'd1;
   logic req_sequence_start = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [2:0] rsp_status;
   logic signed [TB_TIME_BITS:0] rsp_trigger_time_ns;
   logic [23:0] rsp_command_word;

   // predictor copy of the registers and the sequence state
   logic [19:0] cfg_spacing = tdee_pkg::MIN_SPACING_RST;
   logic [23:0] cfg_start = tdee_pkg::MIN_START_RST;
   logic [19:0] cfg_holdoff = tdee_pkg::HOLDOFF_RST;
   logic [23:0] cfg_delay = tdee_pkg::TRIGGER_DELAY_RST;
   logic [TB_TIME_BITS-1:0] last_time = '0;
   logic seq_aborted = 1'b0;

   verdict_type pending_verdicts[$];
   verdict_type want_v;

   int send_idle_pct = 0;
   int stall_pct = 0;
   logic hold_req = 1'b0;
   logic hold_ack = 1'b0;
   int hold_left = 0;
   int idle_cycles = 0;
   int fail_cnt = 0;
   int n_sent = 0;
   int n_ok = 0;
   int n_checked = 0;
   int n_configs = 0;
   longint gen_t = 0;
   int seq_left = 0;

   timed_dac_event_encoder #(.TIME_BITS(TB_TIME_BITS)) dut (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_event_time_ns(req_event_time_ns),
      .req_dac_channel(req_dac_channel),
      .req_voltage_q10(req_voltage_q10),
      .req_events_at_time(req_events_at_time),
      .req_sequence_start(req_sequence_start),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_trigger_time_ns(rsp_trigger_time_ns),
      .rsp_command_word(rsp_command_word)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Work out the verdict of one event and advance the sequence state.
   function automatic verdict_type judge_event(input dac_event_type ev);
      verdict_type v;
      longint t, sp, st, ho, dly, volt, lim, trig, code;
      logic [5:0] sw;
      v = '0;
      t = 0;
      t[TB_TIME_BITS-1:0] = ev.time_ns;
      sp = cfg_spacing;
      st = cfg_start;
      ho = cfg_holdoff;
      dly = $signed(cfg_delay);
      volt = $signed(ev.volt);
      lim = tdee_pkg::VOLT_LIMIT;
      v.status = tdee_pkg::ST_OK;
      if (ev.start) begin
         seq_aborted = 1'b0;
         if (t - sp < st + dly - sp) v.status = tdee_pkg::ST_EARLY;
      end else if (seq_aborted) begin
         v.status = tdee_pkg::ST_ABORTED;
         return v;
      end else begin
         if (t - sp < longint'({16'd0, last_time})) v.status = tdee_pkg::ST_CLOSE;
      end
      if (v.status == tdee_pkg::ST_OK && ev.count > 1) v.status = tdee_pkg::ST_SIMUL;
      if (v.status == tdee_pkg::ST_OK && (volt > lim || volt < -lim)) begin
         v.status = tdee_pkg::ST_RANGE;
      end
      if (v.status != tdee_pkg::ST_OK) begin
         seq_aborted = 1'b1;
         return v;
      end
      trig = t - ho - dly;
      if (trig > TRIG_MAX) trig = TRIG_MAX;
      if (trig < TRIG_MIN) trig = TRIG_MIN;
      v.trig = trig[TB_TIME_BITS:0];
      code = (lim - volt) * CODE_FULL / (2 * lim);
      sw = {ev.channel[5:2], ev.channel[0], ev.channel[1]};
      v.word = {tdee_pkg::RESET_BIT, tdee_pkg::REG_FIELD, sw, tdee_pkg::UPDATE_BIT,
                code[tdee_pkg::CODE_BITS-1:0]};
      last_time = ev.time_ns;
      return v;
   endfunction

   function automatic dac_event_type timed_event(input longint t, input int ch, input int v,
                                                 input int n, input bit s);
      dac_event_type ev;
      ev.time_ns = t[TB_TIME_BITS-1:0];
      ev.channel = 6'(ch);
      ev.volt = 16'(v);
      ev.count = 4'(n);
      ev.start = s;
      return ev;
   endfunction

   // Mostly well-formed sequences in time order, with some early, close and noisy events.
   function automatic dac_event_type random_event();
      dac_event_type ev;
      longint st, dly;
      int r;
      r = $urandom_range(99);
      ev.channel = ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(39));
      if (r < 80) ev.volt = 16'(int'($urandom_range(20480)) - 10240);
      else if (r < 90) ev.volt = ($urandom_range(1) == 1) ? 16'(10240 + int'($urandom_range(1)))
                                                          : 16'(-10240 - int'($urandom_range(1)));
      else ev.volt = 16'($urandom);
      ev.count = ($urandom_range(9) == 0) ? 4'($urandom) : 4'd1;
      r = $urandom_range(99);
      if (r < 8) begin
         ev.time_ns = TB_TIME_BITS'({$urandom, $urandom});
         ev.start = 1'($urandom_range(1));
         return ev;
      end
      if (seq_left == 0 || r < 10) begin
         seq_left = $urandom_range(30, 2);
         ev.start = 1'b1;
         st = cfg_start;
         dly = $signed(cfg_delay);
         r = $urandom_range(99);
         if (r < 20) gen_t = longint'({$urandom, $urandom}) & TRIG_MAX;
         else if (r < 30) gen_t = st + dly - int'($urandom_range(100, 1));
         else gen_t = st + dly + int'($urandom_range(500));
         if (gen_t < 0) gen_t = 0;
      end else begin
         seq_left--;
         ev.start = 1'b0;
         if ($urandom_range(99) < 5) gen_t = gen_t + $urandom_range(cfg_spacing);
         else gen_t = gen_t + cfg_spacing + $urandom_range(2000);
         if (gen_t > TRIG_MAX) gen_t = TRIG_MAX;
      end
      ev.time_ns = gen_t[TB_TIME_BITS-1:0];
      return ev;
   endfunction

   // Offer one item, hold it until accepted, then idle at random.
   task automatic send_event(input dac_event_type ev);
      verdict_type v;
      req_valid <= 1'b1;
      req_event_time_ns <= ev.time_ns;
      req_dac_channel <= ev.channel;
      req_voltage_q10 <= ev.volt;
      req_events_at_time <= ev.count;
      req_sequence_start <= ev.start;
      do @(posedge clock); while (!req_ready);
      v = judge_event(ev);
      pending_verdicts.insert(pending_verdicts.size(), v);
      n_sent++;
      if (v.status == tdee_pkg::ST_OK) n_ok++;
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   task automatic wait_results_drained();
      req_valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [23:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // Write all four registers while the block is idle.
   task automatic load_config(input logic [23:0] sp, input logic [23:0] st,
                              input logic [23:0] ho, input logic [23:0] dl);
      wait_results_drained();
      write_reg(tdee_pkg::CSR_MIN_SPACING, sp);
      write_reg(tdee_pkg::CSR_MIN_START, st);
      write_reg(tdee_pkg::CSR_HOLDOFF, ho);
      write_reg(tdee_pkg::CSR_TRIGGER_DELAY, dl);
      csr_we <= 1'b0;
      cfg_spacing = sp[19:0];
      cfg_start = st;
      cfg_holdoff = ho[19:0];
      cfg_delay = dl;
      n_configs++;
   endtask

   task automatic set_idle(input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      stall_pct <= recv_pct;
   endtask

   task automatic run_random(input int n);
      seq_left = 0;
      repeat (n) send_event(random_event());
   endtask

   task automatic test_directed();
      set_idle(0, 0);
      send_event(timed_event(1050, 0, 0, 1, 0));        // no start since reset
      send_event(timed_event(2099, 1, 0, 1, 0));        // one short of spacing
      send_event(timed_event(50000, 2, 0, 1, 0));       // aborted
      send_event(timed_event(9999, 3, 0, 1, 1));        // one short of start margin
      send_event(timed_event(10000, 39, 10240, 1, 1));  // start margin exact, top voltage
      send_event(timed_event(11050, 63, -10240, 1, 0)); // spacing exact, bottom voltage
      send_event(timed_event(12099, 5, 0, 1, 0));
      send_event(timed_event(20000, 6, 0, 1, 0));
      send_event(timed_event(20000, 7, 0, 2, 1));
      send_event(timed_event(20000, 8, 10241, 1, 1));
      send_event(timed_event(20000, 9, -10241, 1, 1));
      send_event(timed_event(20000, 10, 32767, 1, 1));
      send_event(timed_event(20000, 11, -32768, 1, 1));
      send_event(timed_event(20000, 12, 1, 0, 1));      // zero count acts as one
      send_event(timed_event(21050, 13, 0, 15, 0));
      send_event(timed_event(9000, 14, 20000, 2, 1));   // early wins over the rest
      send_event(timed_event(30000, 15, 20000, 3, 1));  // shared time wins over range
      send_event(timed_event(TRIG_MAX, 62, -1, 1, 1));
      send_event(timed_event(TRIG_MAX, 33, 512, 1, 0));
      send_event(timed_event(0, 0, 0, 1, 1));
      send_event(timed_event(10000, 42, -5, 1, 1));     // channel beyond the board
      send_event(timed_event(11050, 1, 7, 1, 0));
      send_event(timed_event(12100, 2, -7, 1, 0));
   endtask

   task automatic test_idle_phases();
      set_idle(0, 0);
      run_random(230);
      set_idle(49, 0);
      run_random(230);
      set_idle(0, 49);
      run_random(230);
      set_idle(28, 28);
      run_random(230);
   endtask

   // Stop the receiver for a long stretch while items keep coming.
   task automatic test_backpressure();
      set_idle(0, 0);
      hold_req <= ~hold_req;
      run_random(40);
      wait_results_drained();
   endtask

   task automatic test_trigger_limits();
      load_config(24'd1050, 24'd10000, 24'd5150, 24'h800000);
      send_event(timed_event(TRIG_MAX, 21, 100, 1, 1));  // trigger time saturates high
      send_event(timed_event(0, 22, 100, 1, 1));
      set_idle(28, 28);
      run_random(40);
      load_config(24'd0, 24'd0, 24'hFFFFF, 24'h7FFFFF);
      set_idle(0, 0);
      send_event(timed_event(8388606, 23, 0, 1, 1));
      send_event(timed_event(8388607, 24, 0, 1, 1));     // negative trigger time
      send_event(timed_event(8388607, 25, 0, 1, 0));     // zero spacing allows equal time
      set_idle(28, 28);
      run_random(40);
   endtask

   task automatic test_config_sweep();
      set_idle(28, 28);
      load_config(24'd0, 24'd0, 24'd0, 24'd0);
      run_random(60);
      load_config(24'hFFFFF, 24'hFFFFFF, 24'hFFFFF, 24'h7FFFFF);
      run_random(60);
      load_config(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
      run_random(60);
      load_config(24'($urandom_range(3000)), 24'($urandom_range(20000)),
                  24'($urandom_range(8000)), 24'($urandom));
      run_random(60);
      load_config(24'(tdee_pkg::MIN_SPACING_RST), tdee_pkg::MIN_START_RST,
                  24'(tdee_pkg::HOLDOFF_RST), tdee_pkg::TRIGGER_DELAY_RST);
      run_random(60);
   endtask

   always @(posedge clock) begin
      if (hold_req != hold_ack) begin
         hold_ack <= hold_req;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_verdicts.size() == 0) begin
            $error("result with no item pending: status %0d", rsp_status);
            fail_cnt++;
         end else begin
            want_v = pending_verdicts.pop_front();
            n_checked++;
            if (rsp_status !== want_v.status) begin
               $error("status: expected %0d, got %0d", want_v.status, rsp_status);
               fail_cnt++;
            end
            if (rsp_trigger_time_ns !== $signed(want_v.trig)) begin
               $error("trigger_time_ns: expected %0d, got %0d",
                      $signed(want_v.trig), rsp_trigger_time_ns);
               fail_cnt++;
            end
            if (rsp_command_word !== want_v.word) begin
               $error("command_word: expected %06h, got %06h", want_v.word, rsp_command_word);
               fail_cnt++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_idle_phases();
      test_backpressure();
      test_trigger_limits();
      test_config_sweep();
      wait_results_drained();
      repeat (4) @(posedge clock);
      $display("Covered %0d events (%0d encoded, %0d rejected) over %0d register settings.",
               n_sent, n_ok, n_sent - n_ok, n_configs);
      $display("Checked %0d results under four idle mixes and a %0d-cycle receiver hold.",
               n_checked, HOLD_CYCLES);
      if (fail_cnt == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
